[rtl/pli_pkg.sv]
// Shared codes and controller/datapath interface types for the
// piecewise linear interpolator. No dependencies.
package pli_pkg;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] STAT_IN      = 2'd0;
	localparam logic [1:0] STAT_OUTSIDE = 2'd1;
	localparam logic [1:0] STAT_EMPTY   = 2'd2;
	localparam logic [1:0] STAT_SAT     = 2'd3;

	// result source selected by the controller
	localparam logic [1:0] RES_EMPTY = 2'd0;
	localparam logic [1:0] RES_LAST  = 2'd1;
	localparam logic [1:0] RES_Y0    = 2'd2;
	localparam logic [1:0] RES_CALC  = 2'd3;

	typedef struct packed {
		logic       clear;
		logic       append;
		logic       start;
		logic       shift;
		logic       setup;
		logic       mul;
		logic       div_step;
		logic       load_out;
		logic [1:0] res_sel;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic scan_last;
		logic enclosed;
		logic den_zero;
		logic div_last;
		logic out_free;
	} stat_t;

endpackage

[rtl/pli_ctrl.sv]
// Controller FSM for the interpolator: decodes commands, sequences the
// segment scan, multiply, divide and output load. Depends on pli_pkg.
module pli_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_valid,
	input  logic [1:0]     opcode,
	output logic           s_ready,
	input  pli_pkg::stat_t stat,
	output pli_pkg::cmd_t  cmd
);
	import pli_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_FETCH0 = 3'd1;
	localparam logic [2:0] ST_FETCH1 = 3'd2;
	localparam logic [2:0] ST_CHECK  = 3'd3;
	localparam logic [2:0] ST_SETUP  = 3'd4;
	localparam logic [2:0] ST_MUL    = 3'd5;
	localparam logic [2:0] ST_DIV    = 3'd6;
	localparam logic [2:0] ST_OUT    = 3'd7;

	logic [2:0] state_q, state_d;
	logic [1:0] res_sel_q, res_sel_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			res_sel_q <= RES_EMPTY;
		end else begin
			state_q   <= state_d;
			res_sel_q <= res_sel_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		res_sel_d   = res_sel_q;
		s_ready     = 1'b0;
		cmd         = '0;
		cmd.res_sel = res_sel_q;
		unique case (state_q)
			ST_IDLE: begin
				s_ready = 1'b1;
				if (s_valid) begin
					case (opcode)
						OP_CLEAR:  cmd.clear = 1'b1;
						OP_APPEND: cmd.append = 1'b1;
						OP_QUERY: begin
							cmd.start = 1'b1;
							if (stat.count_zero) begin
								res_sel_d = RES_EMPTY;
								state_d   = ST_OUT;
							end else begin
								state_d = ST_FETCH0;
							end
						end
						default: ;
					endcase
				end
			end
			ST_FETCH0: begin
				cmd.shift = 1'b1;
				state_d   = ST_FETCH1;
			end
			ST_FETCH1: begin
				// only one point stored: no segment to test
				if (stat.scan_last) begin
					res_sel_d = RES_LAST;
					state_d   = ST_OUT;
				end else begin
					cmd.shift = 1'b1;
					state_d   = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (stat.enclosed) begin
					state_d = ST_SETUP;
				end else if (stat.scan_last) begin
					res_sel_d = RES_LAST;
					state_d   = ST_OUT;
				end else begin
					cmd.shift = 1'b1;
				end
			end
			ST_SETUP: begin
				if (stat.den_zero) begin
					res_sel_d = RES_Y0;
					state_d   = ST_OUT;
				end else begin
					cmd.setup = 1'b1;
					state_d   = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					res_sel_d = RES_CALC;
					state_d   = ST_OUT;
				end
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[rtl/pli_datapath.sv]
// Datapath for the interpolator: breakpoint memories, scan registers,
// 32x32 multiplier, restoring divider and output register. Depends on pli_pkg.
module pli_datapath #(
	parameter int MAX_POINTS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  pli_pkg::cmd_t  cmd,
	output pli_pkg::stat_t stat,
	input  logic [31:0]    x_value,
	input  logic [31:0]    y_value,
	output logic           m_valid,
	input  logic           m_ready,
	output logic [31:0]    y_result,
	output logic [1:0]     status
);
	import pli_pkg::*;

	localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic signed [33:0] SUM_MAX = 34'sd2147483647;
	localparam logic signed [33:0] SUM_MIN = -34'sd2147483648;

	logic [31:0] mem_x [MAX_POINTS];
	logic [31:0] mem_y [MAX_POINTS];

	logic [CW-1:0] count_q, idx_q;
	logic          full;
	logic [31:0]   xq_q, p0x_q, p0y_q, p1x_q, p1y_q;
	logic [31:0]   num_q, den_q, mag_q, rem_q, quo_q;
	logic          neg_q;
	logic [4:0]    div_cnt_q;
	logic          out_valid_q;
	logic [31:0]   out_y_q;
	logic [1:0]    out_st_q;

	logic signed [32:0] num_w, den_w, dy_w, mag_w;
	logic [63:0]        prod_w;
	logic [33:0]        trial_w;
	logic signed [33:0] sum_w, delta_w;
	logic [31:0]        res_y;
	logic [1:0]         res_st;

	assign full = (count_q == CW'(MAX_POINTS));

	// breakpoint store, one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.append && !full) begin
			mem_x[count_q[AW-1:0]] <= x_value;
			mem_y[count_q[AW-1:0]] <= y_value;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			p1x_q <= mem_x[idx_q[AW-1:0]];
			p1y_q <= mem_y[idx_q[AW-1:0]];
			p0x_q <= p1x_q;
			p0y_q <= p1y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			idx_q       <= '0;
			div_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear)
				count_q <= '0;
			else if (cmd.append && !full)
				count_q <= count_q + CW'(1);
			if (cmd.start)
				idx_q <= '0;
			else if (cmd.shift)
				idx_q <= idx_q + CW'(1);
			if (cmd.mul)
				div_cnt_q <= '0;
			else if (cmd.div_step)
				div_cnt_q <= div_cnt_q + 5'd1;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (m_ready)
				out_valid_q <= 1'b0;
		end
	end

	// segment operands; all nonnegative magnitudes fit 32 bits
	assign num_w = $signed({xq_q[31], xq_q}) - $signed({p0x_q[31], p0x_q});
	assign den_w = $signed({p1x_q[31], p1x_q}) - $signed({p0x_q[31], p0x_q});
	assign dy_w  = $signed({p1y_q[31], p1y_q}) - $signed({p0y_q[31], p0y_q});
	assign mag_w = dy_w[32] ? -dy_w : dy_w;

	assign prod_w  = mag_q * num_q;
	assign trial_w = {1'b0, rem_q, quo_q[31]} - {2'b00, den_q};

	always_ff @(posedge clk) begin
		if (cmd.start)
			xq_q <= x_value;
		if (cmd.setup) begin
			num_q <= num_w[31:0];
			den_q <= den_w[31:0];
			mag_q <= mag_w[31:0];
			neg_q <= dy_w[32];
		end
		// quotient fits 32 bits since num <= den, so the high word starts below den
		if (cmd.mul) begin
			rem_q <= prod_w[63:32];
			quo_q <= prod_w[31:0];
		end else if (cmd.div_step) begin
			if (!trial_w[33]) begin
				rem_q <= trial_w[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
		if (cmd.load_out) begin
			out_y_q  <= res_y;
			out_st_q <= res_st;
		end
	end

	assign delta_w = neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
	assign sum_w   = $signed({{2{p0y_q[31]}}, p0y_q}) + delta_w;

	always_comb begin
		res_y  = '0;
		res_st = STAT_EMPTY;
		case (cmd.res_sel)
			RES_EMPTY: begin
				res_y  = '0;
				res_st = STAT_EMPTY;
			end
			RES_LAST: begin
				res_y  = p1y_q;
				res_st = STAT_OUTSIDE;
			end
			RES_Y0: begin
				res_y  = p0y_q;
				res_st = STAT_IN;
			end
			RES_CALC: begin
				if (sum_w > SUM_MAX) begin
					res_y  = 32'h7FFF_FFFF;
					res_st = STAT_SAT;
				end else if (sum_w < SUM_MIN) begin
					res_y  = 32'h8000_0000;
					res_st = STAT_SAT;
				end else begin
					res_y  = sum_w[31:0];
					res_st = STAT_IN;
				end
			end
			default: ;
		endcase
	end

	assign stat.count_zero = (count_q == '0);
	assign stat.scan_last  = (idx_q == count_q);
	assign stat.enclosed   = ($signed(xq_q) >= $signed(p0x_q)) && ($signed(xq_q) <= $signed(p1x_q));
	assign stat.den_zero   = (p0x_q == p1x_q);
	assign stat.div_last   = &div_cnt_q;
	assign stat.out_free   = !out_valid_q || m_ready;

	assign m_valid  = out_valid_q;
	assign y_result = out_y_q;
	assign status   = out_st_q;

endmodule

[rtl/piecewise_linear_interpolator.sv]
// Piecewise linear interpolator over up to MAX_POINTS Q16.16 breakpoints.
// Clear and append give no result.
// Query: an empty table goes straight to the result; otherwise the scan reads one point per cycle
// from the breakpoint memory, then a hit in a segment of nonzero width runs setup, multiply
// and restoring divide steps before its result is loaded. One query at a time.
// arst_n clears the point count and all control; breakpoint memory is not cleared.
module piecewise_linear_interpolator #(
	parameter int MAX_POINTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // x_value[31:0], y_value[63:32]
	input  logic [1:0]  s_axis_tuser,  // opcode[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // y_result[31:0]
	output logic [1:0]  m_axis_tuser   // status[1:0]
);
	import pli_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	pli_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.opcode  (s_axis_tuser),
		.s_ready (s_axis_tready),
		.stat    (stat),
		.cmd     (cmd)
	);

	pli_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.x_value  (s_axis_tdata[31:0]),
		.y_value  (s_axis_tdata[63:32]),
		.m_valid  (m_axis_tvalid),
		.m_ready  (m_axis_tready),
		.y_result (m_axis_tdata),
		.status   (m_axis_tuser)
	);

endmodule

[rtl/pli_checker.sv]
// Port-level checks for piecewise_linear_interpolator, bound to the top level.
// Depends on pli_pkg.
module pli_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [1:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);
	import pli_pkg::*;

	logic s_fire;
	assign s_fire = s_axis_tvalid && s_axis_tready;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result transaction dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_axis_tuser == OP_QUERY |=> !s_axis_tready)
		else $error("input taken while query in progress");

	a_cmd_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_fire && s_axis_tuser != OP_QUERY |=> s_axis_tready)
		else $error("not ready after table command");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == STAT_EMPTY |-> m_axis_tdata == 32'd0)
		else $error("empty-table result not zero");

endmodule

bind piecewise_linear_interpolator pli_checker u_pli_checker (.*);
